/* src/dwr_pkg.sv */
// Package for the double-ended queue with reverse.
// Holds sizing constants, the request code type and the structs passed
// between the controller and the top level. No dependencies.
package dwr_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    ACT_PUSH_HEAD = 2'd0,
    ACT_PUSH_TAIL = 2'd1,
    ACT_POP_HEAD  = 2'd2,
    ACT_REVERSE   = 2'd3
  } action_e;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
  } mem_req_t;

  typedef struct packed {
    logic             success;
    logic             popped;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

/* src/dwr_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module dwr_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                          wdata_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/dwr_ctrl.sv */
// Front index, occupancy and reversed flag; turns each request into a
// RAM access and a result descriptor. Depends on dwr_pkg.
module dwr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  dwr_pkg::action_e  action_i,
  output dwr_pkg::mem_req_t mem_req_o,
  output dwr_pkg::res_t     res_o
);

  localparam logic [dwr_pkg::IDX_W-1:0] LastIdx = dwr_pkg::IDX_W'(dwr_pkg::DEPTH - 1);
  localparam logic [dwr_pkg::IDX_W:0]   DepthW  = (dwr_pkg::IDX_W + 1)'(dwr_pkg::DEPTH);
  localparam logic [dwr_pkg::CNT_W-1:0] FullCnt = dwr_pkg::CNT_W'(dwr_pkg::DEPTH);

  logic [dwr_pkg::IDX_W-1:0] front_q, front_d;
  logic [dwr_pkg::CNT_W-1:0] occ_q, occ_d;
  logic                      rev_q, rev_d;

  logic                      full, empty;
  logic [dwr_pkg::IDX_W-1:0] front_dec, front_inc, slot_hi, slot_last;
  logic [dwr_pkg::IDX_W:0]   sum_hi, sum_last;
  logic [dwr_pkg::CNT_W-1:0] occ_m1;

  assign full      = (occ_q == FullCnt);
  assign empty     = (occ_q == '0);
  assign occ_m1    = occ_q - 1'b1;
  assign front_dec = (front_q == '0) ? LastIdx : front_q - 1'b1;
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + 1'b1;

  // slot just above the run, and the last occupied slot
  assign sum_hi    = {1'b0, front_q} + (dwr_pkg::IDX_W + 1)'(occ_q);
  assign sum_last  = {1'b0, front_q} + (dwr_pkg::IDX_W + 1)'(occ_m1);
  assign slot_hi   = (sum_hi   >= DepthW) ? dwr_pkg::IDX_W'(sum_hi - DepthW)
                                          : sum_hi[dwr_pkg::IDX_W-1:0];
  assign slot_last = (sum_last >= DepthW) ? dwr_pkg::IDX_W'(sum_last - DepthW)
                                          : sum_last[dwr_pkg::IDX_W-1:0];

  always_comb begin
    front_d        = front_q;
    occ_d          = occ_q;
    rev_d          = rev_q;
    mem_req_o      = '0;
    res_o.success  = 1'b0;
    res_o.popped   = 1'b0;
    case (action_i)
      dwr_pkg::ACT_PUSH_HEAD, dwr_pkg::ACT_PUSH_TAIL: begin
        if (!full) begin
          res_o.success = 1'b1;
          occ_d         = occ_q + 1'b1;
          mem_req_o.we  = accept_i;
          // head goes low in normal order, tail goes high
          if ((action_i == dwr_pkg::ACT_PUSH_HEAD) != rev_q) begin
            front_d        = front_dec;
            mem_req_o.addr = front_dec;
          end else begin
            mem_req_o.addr = slot_hi;
          end
        end
      end
      dwr_pkg::ACT_POP_HEAD: begin
        if (!empty) begin
          res_o.success = 1'b1;
          res_o.popped  = 1'b1;
          occ_d         = occ_m1;
          mem_req_o.re  = accept_i;
          if (rev_q) begin
            mem_req_o.addr = slot_last;
          end else begin
            mem_req_o.addr = front_q;
            front_d        = front_inc;
          end
        end
      end
      dwr_pkg::ACT_REVERSE: begin
        res_o.success = 1'b1;
        rev_d         = !rev_q;
      end
      default: begin
        res_o.success = 1'b0;
      end
    endcase
    res_o.count = occ_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      occ_q   <= '0;
      rev_q   <= 1'b0;
    end else if (accept_i) begin
      front_q <= front_d;
      occ_q   <= occ_d;
      rev_q   <= rev_d;
    end
  end

endmodule

/* src/deque_with_reverse.sv */
// Top level of the bounded double-ended queue with reverse.
// Depends on dwr_pkg, dwr_ctrl and dwr_ram.

// One request is taken per cycle while in_ready_o is high. The accepting edge
// updates the pointers and does the RAM access, and a removed word lands in the
// RAM's read register; the result register is loaded from there once the output
// stage can advance. A result register with its own valid lets one further
// request be taken while an earlier result waits. Words live in a 16-entry
// single-port RAM; reverse only toggles a flag. Entries are never read before
// written, so the RAM needs no clearing after reset.
module deque_with_reverse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [dwr_pkg::VALUE_W-1:0] entry_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        success_o,
  output logic [dwr_pkg::VALUE_W-1:0] removed_value_o,
  output logic [dwr_pkg::COUNT_OUT_W-1:0] entry_count_o
);

  logic                          accept;
  logic                          s1_adv;
  dwr_pkg::mem_req_t             mem_req;
  dwr_pkg::res_t                 res;
  logic [dwr_pkg::WORD_BITS-1:0] rdata;

  logic                          s1_valid_q;
  dwr_pkg::res_t                 s1_res_q;
  logic                          out_valid_q;
  logic                          success_q;
  logic [dwr_pkg::VALUE_W-1:0]   removed_q;
  logic [dwr_pkg::COUNT_OUT_W-1:0] count_q;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  dwr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .action_i  (dwr_pkg::action_e'(action_i)),
    .mem_req_o (mem_req),
    .res_o     (res)
  );

  dwr_ram #(
    .Depth (dwr_pkg::DEPTH),
    .Width (dwr_pkg::WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (entry_value_i[dwr_pkg::WORD_BITS-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // read data holds while stage one stalls: no new request means no new read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (s1_adv && s1_valid_q) begin
      success_q <= s1_res_q.success;
      removed_q <= s1_res_q.popped ? dwr_pkg::VALUE_W'(rdata) : '0;
      count_q   <= dwr_pkg::COUNT_OUT_W'(s1_res_q.count);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign success_o       = success_q;
  assign removed_value_o = removed_q;
  assign entry_count_o   = count_q;

endmodule

/* tb/deque_with_reverse_tb.sv */
// Self-checking testbench for deque_with_reverse: directed and random requests
// checked against a ring-store predictor, with random stalls on both channels.
// Depends on dwr_pkg and the deque_with_reverse RTL.
module deque_with_reverse_tb;

  localparam int unsigned RUN_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned LONG_HOLD    = 300;

  typedef struct packed {
    logic                            success;
    logic [dwr_pkg::VALUE_W-1:0]     removed;
    logic [dwr_pkg::COUNT_OUT_W-1:0] count;
  } deque_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [1:0]                      action_i;
  logic [dwr_pkg::VALUE_W-1:0]     entry_value_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic                            success_o;
  logic [dwr_pkg::VALUE_W-1:0]     removed_value_o;
  logic [dwr_pkg::COUNT_OUT_W-1:0] entry_count_o;

  // predictor state
  logic [dwr_pkg::VALUE_W-1:0] ring_words [dwr_pkg::DEPTH];
  int unsigned                 ring_front;
  int unsigned                 ring_count;
  bit                          ring_flipped;

  deque_result_t pending_results [$];
  deque_result_t next_expected;

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned full_refusals;
  int unsigned empty_refusals;
  int unsigned reversals;
  int unsigned peak_count;

  // sender idling
  int unsigned burst_left;
  int unsigned burst_max;
  int unsigned gap_max;

  // receiver stall pattern
  int unsigned stall_pct;
  int unsigned stall_run_max;
  int unsigned ready_run;
  int unsigned hold_left;
  bit          long_hold_req;

  deque_with_reverse dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .entry_value_i  (entry_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .success_o      (success_o),
    .removed_value_o(removed_value_o),
    .entry_count_o  (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0d: %s", cycle_count, msg);
  endfunction

  // ring-store model; pushes the expected result of one request
  function automatic void predict_request(dwr_pkg::action_e act,
                                          logic [dwr_pkg::VALUE_W-1:0] word);
    deque_result_t r;
    bit            go_low;
    r = '0;
    case (act)
      dwr_pkg::ACT_PUSH_HEAD, dwr_pkg::ACT_PUSH_TAIL: begin
        if (ring_count < dwr_pkg::DEPTH) begin
          go_low = (act == dwr_pkg::ACT_PUSH_HEAD) ^ ring_flipped;
          if (go_low) begin
            ring_front = (ring_front + dwr_pkg::DEPTH - 1) % dwr_pkg::DEPTH;
            ring_words[ring_front] = word;
          end else begin
            ring_words[(ring_front + ring_count) % dwr_pkg::DEPTH] = word;
          end
          ring_count++;
          r.success = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      dwr_pkg::ACT_POP_HEAD: begin
        if (ring_count > 0) begin
          if (ring_flipped) begin
            r.removed = ring_words[(ring_front + ring_count - 1) % dwr_pkg::DEPTH];
          end else begin
            r.removed = ring_words[ring_front];
            ring_front = (ring_front + 1) % dwr_pkg::DEPTH;
          end
          ring_count--;
          r.success = 1'b1;
        end else begin
          empty_refusals++;
        end
      end
      default: begin
        ring_flipped = !ring_flipped;
        reversals++;
        r.success = 1'b1;
      end
    endcase
    r.count = dwr_pkg::COUNT_OUT_W'(ring_count);
    if (ring_count > peak_count) peak_count = ring_count;
    pending_results.push_back(r);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result: success=%0b removed=%h count=%0d",
                             success_o, removed_value_o, entry_count_o));
      end else begin
        next_expected = pending_results.pop_front();
        results_seen++;
        if (success_o !== next_expected.success ||
            removed_value_o !== next_expected.removed ||
            entry_count_o !== next_expected.count) begin
          note_error($sformatf("result %0d: exp success=%0b removed=%h count=%0d, got %0b %h %0d",
                               results_seen, next_expected.success, next_expected.removed,
                               next_expected.count, success_o, removed_value_o,
                               entry_count_o));
        end
      end
    end
  end

  // receiver: stretches of ready/stall of random length, plus one long hold
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      hold_left = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else if (stall_pct == 0) begin
      out_ready_i = 1'b1;
      ready_run = 0;
    end else if (ready_run > 0) begin
      ready_run--;
    end else begin
      out_ready_i = ($urandom_range(1, 100) > stall_pct);
      ready_run = $urandom_range(0, stall_run_max);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input dwr_pkg::action_e act,
                              input logic [dwr_pkg::VALUE_W-1:0] word);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(0, gap_max)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    in_valid_i = 1'b1;
    action_i = act;
    entry_value_i = word;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(act, word);
    requests_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic [dwr_pkg::VALUE_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return dwr_pkg::VALUE_W'(1) << $urandom_range(0, dwr_pkg::VALUE_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic dwr_pkg::action_e pick_action(int unsigned push_pct,
                                                   int unsigned pop_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      return ($urandom_range(0, 1) == 0) ? dwr_pkg::ACT_PUSH_HEAD : dwr_pkg::ACT_PUSH_TAIL;
    end
    if (roll < push_pct + pop_pct) return dwr_pkg::ACT_POP_HEAD;
    return dwr_pkg::ACT_REVERSE;
  endfunction

  task automatic set_idling(input int unsigned gaps, input int unsigned bursts,
                            input int unsigned stall, input int unsigned stall_run);
    gap_max = gaps;
    burst_max = bursts;
    burst_left = 0;
    stall_pct = stall;
    stall_run_max = stall_run;
  endtask

  task automatic test_empty_and_reverse();
    set_idling(2, 3, 30, 3);
    send_request(dwr_pkg::ACT_POP_HEAD, '1);
    send_request(dwr_pkg::ACT_REVERSE, '1);
    send_request(dwr_pkg::ACT_PUSH_HEAD, '0);
    send_request(dwr_pkg::ACT_PUSH_TAIL, '1);
    send_request(dwr_pkg::ACT_REVERSE, '0);
    send_request(dwr_pkg::ACT_POP_HEAD, '0);
    send_request(dwr_pkg::ACT_POP_HEAD, '1);
    send_request(dwr_pkg::ACT_POP_HEAD, '0);
  endtask

  task automatic test_fill_to_capacity();
    logic [dwr_pkg::VALUE_W-1:0] pattern;
    set_idling(0, 1, 0, 0);
    for (int i = 0; i < dwr_pkg::DEPTH; i++) begin
      pattern = dwr_pkg::VALUE_W'(1) << ((i * 4) % dwr_pkg::VALUE_W);
      if (i % 2) pattern = ~pattern;
      send_request((i % 2) ? dwr_pkg::ACT_PUSH_TAIL : dwr_pkg::ACT_PUSH_HEAD, pattern);
    end
    send_request(dwr_pkg::ACT_PUSH_HEAD, {(dwr_pkg::VALUE_W/2){2'b01}});
    send_request(dwr_pkg::ACT_PUSH_TAIL, {(dwr_pkg::VALUE_W/2){2'b10}});
  endtask

  task automatic test_random_mix(input int unsigned n, input int unsigned push_pct,
                                 input int unsigned pop_pct);
    for (int unsigned i = 0; i < n; i++) send_request(pick_action(push_pct, pop_pct),
                                                      random_word());
  endtask

  task automatic test_long_backpressure();
    set_idling(0, 1, 0, 0);
    @(posedge clk_i);
    long_hold_req = 1'b1;
    @(negedge clk_i);
    test_random_mix(60, 45, 40);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = dwr_pkg::ACT_PUSH_HEAD;
    entry_value_i = '0;
    out_ready_i = 1'b0;
    long_hold_req = 1'b0;
    hold_left = 0;
    ready_run = 0;
    ring_front = 0;
    ring_count = 0;
    ring_flipped = 1'b0;
    set_idling(0, 1, 0, 0);
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_and_reverse();
    test_fill_to_capacity();

    set_idling(0, 1, 0, 0);
    test_random_mix(300, 30, 60);
    set_idling(4, 12, 30, 6);
    test_random_mix(300, 62, 28);
    set_idling(2, 8, 60, 8);
    test_random_mix(300, 45, 45);
    test_long_backpressure();
    set_idling(8, 20, 20, 4);
    test_random_mix(300, 72, 20);
    set_idling(1, 4, 50, 3);
    test_random_mix(300, 20, 72);
    set_idling(3, 10, 40, 5);
    test_random_mix(300, 35, 35);

    in_valid_i = 1'b0;
    set_idling(0, 1, 0, 0);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests, %0d results, %0d reversals, peak fill %0d of %0d",
             requests_sent, results_seen, reversals, peak_count, dwr_pkg::DEPTH);
    $display("refused: %0d inserts on full, %0d removes on empty; %0d errors",
             full_refusals, empty_refusals, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
src/dwr_pkg.sv
src/dwr_ram.sv
src/dwr_ctrl.sv
src/deque_with_reverse.sv
tb/deque_with_reverse_tb.sv
